// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_CLK_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NORST(label, clk, prop)
`endif
`endif

// ----- sv/bcp_pkg.sv -----
package bcp_pkg;

  // request actions
  typedef enum logic [1:0] {
    ACT_KNOT  = 2'd0,
    ACT_POINT = 2'd1,
    ACT_EVAL  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // configuration register indexes
  localparam logic REG_DEGREE = 1'b0;
  localparam logic REG_LAST   = 1'b1;

  localparam int IDX_W    = 8;   // internal knot / point index width
  localparam int KNOT_W   = 16;
  localparam int COORD_W  = 32;
  localparam int BASIS_W  = 31;  // unsigned Q.30, at most 1.0
  localparam int NUM_W    = 46;  // basis << 15
  localparam int DEN_W    = 17;  // sum of two knot differences
  localparam int ACC_W    = 66;
  localparam int FRAC_SH  = 15;

  localparam logic [4:0] SEARCH_LAST = 5'd31;
  localparam logic [BASIS_W-1:0] ONE_Q30 = BASIS_W'(1) << 30;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- sv/bcp_div.sv -----
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle.
module bcp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bcp_pkg::NUM_W-1:0]   num,
  input  logic [bcp_pkg::DEN_W-1:0]   den,
  output bcp_pkg::div_stat_t          stat,
  output logic [bcp_pkg::NUM_W-1:0]   quo
);

  localparam int CNT_W = $clog2(bcp_pkg::NUM_W + 1);

  logic [bcp_pkg::DEN_W-1:0] divisor;
  logic [bcp_pkg::DEN_W-1:0] rem;
  logic [bcp_pkg::DEN_W:0]   rem_sh;
  logic [CNT_W-1:0]          count;
  logic                      busy;
  logic                      done;

  assign rem_sh = {rem, quo[bcp_pkg::NUM_W-1]};
  assign stat   = '{busy: busy, done: done};

  // shift numerator out, quotient bits in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      // done pulses together with the last quotient bit
      done <= busy && (count == CNT_W'(1));
      if (start) begin
        busy    <= 1'b1;
        count   <= CNT_W'(bcp_pkg::NUM_W);
        quo     <= num;
        divisor <= den;
        rem     <= '0;
      end else if (busy) begin
        if (rem_sh >= {1'b0, divisor}) begin
          rem <= bcp_pkg::DEN_W'(rem_sh - {1'b0, divisor});
          quo <= {quo[bcp_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem <= bcp_pkg::DEN_W'(rem_sh);
          quo <= {quo[bcp_pkg::NUM_W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  `ASSERT_CLK(a_done_after_busy, clk, rst, done |-> $past(busy))
  `ASSERT_CLK(a_busy_count, clk, rst, busy |-> count != '0)
  `ASSERT_CLK(a_no_restart, clk, rst, start |-> !busy)

endmodule

// ----- sv/bspline_curve_point.sv -----
// Writes (knot or control point) are taken back to back while no evaluation is running.
// Evaluate: a search for the knot span, then p(p+1)/2 basis steps, each using the 46-step
// bit-serial divider unless its denominator is zero. The next request is taken the cycle
// the result appears; a finished result waits in the output register.
// rst (synchronous) clears control state, sets degree 3, last index 3; memories keep no reset.
`include "assert_macros.svh"

module bspline_curve_point #(
  parameter int MAX_DEGREE = 7,
  parameter int MAX_POINTS = 64,
  parameter int KNOT_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  action,
  input  logic [6:0]  store_index,
  input  logic [15:0] knot_word,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic [15:0] param_u,
  output logic        res_valid,
  input  logic        res_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic [6:0]  span_found
);

  localparam int KAW = $clog2(KNOT_DEPTH);
  localparam int PAW = $clog2(MAX_POINTS);
  localparam int DGW = $clog2(MAX_DEGREE + 1);
  localparam int IW  = bcp_pkg::IDX_W;
  localparam int BW  = bcp_pkg::BASIS_W;
  localparam int AW  = bcp_pkg::ACC_W;

  typedef enum logic [4:0] {
    S_IDLE, S_RLO, S_RHI, S_CLAMP, S_SM, S_SM1, S_SCHK,
    S_LR0, S_LR1, S_LR2, S_DEN, S_DIV, S_M1, S_M2,
    S_PT, S_PACC, S_DONE
  } state_t;

  function automatic logic signed [31:0] sat_round(input logic signed [AW-1:0] s);
    logic signed [AW-1:0] v;
    logic signed [AW-1:0] q;
    v = s + (AW'(1) <<< 29);
    q = v >>> 30;
    if (q > AW'(64'sd2147483647)) return 32'sh7fffffff;
    if (q < -(AW'(64'sd2147483648))) return 32'sh80000000;
    return 32'(q);
  endfunction

  state_t state;

  // configuration
  logic [2:0] curve_degree;
  logic [5:0] last_control_index;

  // evaluation registers
  logic [DGW-1:0]      p;
  logic [5:0]          n;
  logic [15:0]         u;
  logic [15:0]         klo;
  logic [15:0]         km;
  logic [IW-1:0]       low, high, mid, span;
  logic [4:0]          it;
  logic [DGW-1:0]      j, r;
  logic [BW-1:0]       saved;
  logic [bcp_pkg::NUM_W-1:0] temp;
  logic [BW-1:0]       basis [MAX_DEGREE+1];
  logic [15:0]         left  [MAX_DEGREE+1];
  logic [15:0]         right [MAX_DEGREE+1];
  logic signed [AW-1:0] acc_x, acc_y;

  // memories
  logic [15:0] knot_mem [KNOT_DEPTH];
  logic [31:0] px_mem   [MAX_POINTS];
  logic [31:0] py_mem   [MAX_POINTS];
  logic [15:0] knot_q;
  logic        k_ok_q;
  logic [31:0] px_q, py_q;
  logic        p_ok_q;

  logic          req_acc;
  logic [IW-1:0] kidx, pidx;
  logic          k_ok, p_ok;
  logic [15:0]   kd;
  logic [15:0]   u_c;
  logic [IW-1:0] mid_n, low_n, high_n;
  logic [bcp_pkg::DEN_W-1:0] den;
  logic [62:0]   mul_p;
  logic [16:0]   mul_a;
  logic signed [63:0] prod_x, prod_y;
  logic signed [31:0] pxv, pyv;
  logic [DGW-1:0] jr;
  logic          div_start;
  bcp_pkg::div_stat_t div_stat;
  logic [bcp_pkg::NUM_W-1:0] div_quo;
  int            p_calc;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign jr        = DGW'(j - r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_degree       <= 3'd3;
      last_control_index <= 6'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcp_pkg::REG_DEGREE: curve_degree       <= cfg_data[2:0];
        bcp_pkg::REG_LAST:   last_control_index <= cfg_data;
        default: ;
      endcase
    end
  end

  // knot read address per state
  always_comb begin
    unique case (state)
      S_RLO:   kidx = IW'(p);
      S_RHI:   kidx = IW'(n) + IW'(1);
      S_SM:    kidx = mid;
      S_SM1:   kidx = mid + IW'(1);
      S_LR0:   kidx = span - IW'(j);
      S_LR1:   kidx = span + IW'(j) + IW'(1);
      default: kidx = '0;
    endcase
    k_ok = int'(kidx) < KNOT_DEPTH;
    pidx = span - IW'(p) + IW'(j);
    p_ok = int'(pidx) < MAX_POINTS;
  end

  // knot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (req_acc && action == bcp_pkg::ACT_KNOT && int'(store_index) < KNOT_DEPTH)
      knot_mem[KAW'(store_index)] <= knot_word;
    knot_q <= knot_mem[KAW'(kidx)];
    k_ok_q <= k_ok;
  end

  // control point memories
  always_ff @(posedge clk) begin
    if (req_acc && action == bcp_pkg::ACT_POINT && int'(store_index) < MAX_POINTS) begin
      px_mem[PAW'(store_index)] <= coord_x;
      py_mem[PAW'(store_index)] <= coord_y;
    end
    px_q   <= px_mem[PAW'(pidx)];
    py_q   <= py_mem[PAW'(pidx)];
    p_ok_q <= p_ok;
  end

  assign kd = k_ok_q ? knot_q : '0;

  // datapath helpers
  always_comb begin
    p_calc = int'(curve_degree);
    if (p_calc > MAX_DEGREE) p_calc = MAX_DEGREE;
    if (p_calc > int'(last_control_index)) p_calc = int'(last_control_index);
    u_c = (u < klo) ? klo : u;
    if (u_c > kd) u_c = kd;
    if (u < km) begin
      high_n = mid;
      low_n  = low;
    end else begin
      high_n = high;
      low_n  = mid;
    end
    mid_n  = IW'(({1'b0, low_n} + {1'b0, high_n}) >> 1);
    den    = {1'b0, right[r]} + {1'b0, left[jr]};
    mul_a  = (state == S_M1) ? {1'b0, right[r]} : {1'b0, left[jr]};
    mul_p  = 63'(mul_a) * 63'(temp);
    pxv    = p_ok_q ? $signed(px_q) : 32'sd0;
    pyv    = p_ok_q ? $signed(py_q) : 32'sd0;
    prod_x = $signed({1'b0, basis[j]}) * pxv;
    prod_y = $signed({1'b0, basis[j]}) * pyv;
  end

  assign div_start = (state == S_DEN) && (den != '0);

  bcp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({basis[r], 15'd0}),
    .den   (den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // evaluation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_DONE) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_acc && action == bcp_pkg::ACT_EVAL) begin
            p     <= DGW'(p_calc);
            n     <= last_control_index;
            u     <= param_u;
            state <= S_RLO;
          end
        end
        S_RLO:   state <= S_RHI;
        S_RHI: begin
          klo   <= kd;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          u        <= u_c;
          basis[0] <= bcp_pkg::ONE_Q30;
          j        <= '0;
          if (u_c == klo) begin
            span  <= IW'(p);
            state <= S_LR0;
          end else if (u_c == kd) begin
            span  <= IW'(n);
            state <= S_LR0;
          end else begin
            low   <= IW'(p);
            high  <= IW'(n) + IW'(1);
            mid   <= IW'((IW'(p) + IW'(n) + IW'(1)) >> 1);
            it    <= '0;
            state <= S_SM;
          end
        end
        S_SM:  state <= S_SM1;
        S_SM1: begin
          km    <= kd;
          state <= S_SCHK;
        end
        S_SCHK: begin
          if (!(u < km || u >= kd)) begin
            span  <= mid;
            state <= S_LR0;
          end else begin
            low  <= low_n;
            high <= high_n;
            mid  <= mid_n;
            it   <= it + 5'd1;
            if (it == bcp_pkg::SEARCH_LAST) begin
              span  <= mid_n;
              state <= S_LR0;
            end else begin
              state <= S_SM;
            end
          end
        end
        S_LR0: begin
          if (j == p) begin
            j     <= '0;
            acc_x <= '0;
            acc_y <= '0;
            state <= S_PT;
          end else begin
            state <= S_LR1;
          end
        end
        S_LR1: begin
          left[j] <= (u > kd) ? u - kd : '0;
          state   <= S_LR2;
        end
        S_LR2: begin
          right[j] <= (kd > u) ? kd - u : '0;
          r        <= '0;
          saved    <= '0;
          state    <= S_DEN;
        end
        S_DEN: begin
          if (den == '0) begin
            temp  <= '0;
            state <= S_M1;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            temp  <= div_quo;
            state <= S_M1;
          end
        end
        S_M1: begin
          basis[r] <= saved + BW'(mul_p >> bcp_pkg::FRAC_SH);
          state    <= S_M2;
        end
        S_M2: begin
          saved <= BW'(mul_p >> bcp_pkg::FRAC_SH);
          if (r == j) begin
            basis[j + DGW'(1)] <= BW'(mul_p >> bcp_pkg::FRAC_SH);
            j     <= j + DGW'(1);
            state <= S_LR0;
          end else begin
            r     <= r + DGW'(1);
            state <= S_DEN;
          end
        end
        S_PT:  state <= S_PACC;
        S_PACC: begin
          acc_x <= acc_x + AW'(prod_x);
          acc_y <= acc_y + AW'(prod_y);
          if (j == p) begin
            state <= S_DONE;
          end else begin
            j     <= j + DGW'(1);
            state <= S_PT;
          end
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid  <= 1'b1;
            point_x    <= sat_round(acc_x);
            point_y    <= sat_round(acc_y);
            span_found <= 7'(span);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_result_from_done, clk, rst, $rose(res_valid) |-> $past(state) == S_DONE)
  `ASSERT_CLK(a_div_nonzero, clk, rst, div_start |-> den != '0 && !div_stat.busy)
  `ASSERT_CLK(a_span_range, clk, rst, state == S_DONE |-> span >= IW'(p) && span <= IW'(n))
  `ASSERT_CLK(a_div_wait, clk, rst, state == S_DIV |-> div_stat.busy || div_stat.done)

endmodule
